/* rtl/core/damage_rect_accumulator_core_assert.svh */
`ifndef DAMAGE_RECT_ACCUMULATOR_CORE_ASSERT_SVH
`define DAMAGE_RECT_ACCUMULATOR_CORE_ASSERT_SVH

// same-cycle implication
`define DRAC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DRAC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/drac_pkg.sv */
`timescale 1ns / 1ps
package drac_pkg;

	localparam int MAX_RECTS_DEF = 16;
	localparam int SCREEN_LIMIT  = 8192;
	localparam int DIM_W         = 14;
	localparam int POS_W         = 13;
	localparam int IN_W          = 16;

	localparam logic [DIM_W-1:0] WIDTH_RST  = 14'd1024;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 14'd768;

	localparam logic [1:0] MODE_ADD  = 2'd0;
	localparam logic [1:0] MODE_FULL = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;

	localparam logic [2:0] ST_ADDED = 3'd0;
	localparam logic [2:0] ST_DROP  = 3'd1;
	localparam logic [2:0] ST_OVF   = 3'd2;
	localparam logic [2:0] ST_FULL  = 3'd3;
	localparam logic [2:0] ST_RO    = 3'd4;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
	} rect_t;

	typedef struct packed {
		logic  near;
		rect_t box;
	} geom_t;

	typedef struct packed {
		logic       empty;
		rect_t      box;
	} clip_t;

	typedef struct packed {
		logic [2:0] status;
		rect_t      box;
		logic       valid;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_RD_I,
		S_LD_I,
		S_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_EMIT,
		S_RO_RD,
		S_RO_OUT
	} state_t;

endpackage

/* rtl/core/drac_mem.sv */
`timescale 1ns / 1ps
module drac_mem #(
	parameter int DEPTH = drac_pkg::MAX_RECTS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wa,
	input  drac_pkg::rect_t          wd,
	input  logic [$clog2(DEPTH)-1:0] ra,
	output drac_pkg::rect_t          rd
);

	drac_pkg::rect_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd <= mem[ra];
	end

endmodule

/* rtl/core/drac_clip.sv */
`timescale 1ns / 1ps
module drac_clip (
	input  logic signed [drac_pkg::IN_W-1:0]  rect_x,
	input  logic signed [drac_pkg::IN_W-1:0]  rect_y,
	input  logic signed [drac_pkg::IN_W-1:0]  rect_w,
	input  logic signed [drac_pkg::IN_W-1:0]  rect_h,
	input  logic        [drac_pkg::DIM_W-1:0] fw,
	input  logic        [drac_pkg::DIM_W-1:0] fh,
	output drac_pkg::clip_t                   clip
);

	typedef struct packed {
		logic              ok;
		logic signed [17:0] p;
		logic signed [17:0] l;
	} axis_t;

	function automatic axis_t clip_axis(input logic signed [15:0] pos,
			input logic signed [15:0] len, input logic [13:0] lim);
		axis_t r;
		logic signed [17:0] lm;
		lm   = $signed({4'b0000, lim});
		r.p  = 18'(pos);
		r.l  = 18'(len);
		r.ok = 1'b0;
		if (r.l > 18'sd0) begin
			if (r.p < 18'sd0) begin
				r.l = r.l + r.p;
				r.p = 18'sd0;
			end
			if (r.p + r.l > lm) begin
				r.l = lm - r.p;
			end
			r.ok = r.l > 18'sd0;
		end
		return r;
	endfunction

	axis_t ax, ay;

	always_comb begin
		ax         = clip_axis(rect_x, rect_w, fw);
		ay         = clip_axis(rect_y, rect_h, fh);
		clip.empty = !(ax.ok && ay.ok);
		clip.box.x = ax.p[drac_pkg::POS_W-1:0];
		clip.box.y = ay.p[drac_pkg::POS_W-1:0];
		clip.box.w = ax.l[drac_pkg::DIM_W-1:0];
		clip.box.h = ay.l[drac_pkg::DIM_W-1:0];
	end

endmodule

/* rtl/core/drac_geom.sv */
`timescale 1ns / 1ps
module drac_geom (
	input  drac_pkg::rect_t a,
	input  drac_pkg::rect_t b,
	output drac_pkg::geom_t g
);

	logic [14:0] ax1, ay1, bx1, by1, ax2, ay2, bx2, by2;
	logic [14:0] mx, my, ex, ey;

	always_comb begin
		ax1 = {2'b00, a.x};
		ay1 = {2'b00, a.y};
		bx1 = {2'b00, b.x};
		by1 = {2'b00, b.y};
		ax2 = ax1 + {1'b0, a.w};
		ay2 = ay1 + {1'b0, a.h};
		bx2 = bx1 + {1'b0, b.w};
		by2 = by1 + {1'b0, b.h};
		g.near = (ax1 <= bx2 + 15'd1) && (bx1 <= ax2 + 15'd1) &&
			(ay1 <= by2 + 15'd1) && (by1 <= ay2 + 15'd1);
		mx = (ax1 < bx1) ? ax1 : bx1;
		my = (ay1 < by1) ? ay1 : by1;
		ex = (ax2 > bx2) ? ax2 : bx2;
		ey = (ay2 > by2) ? ay2 : by2;
		g.box.x = mx[drac_pkg::POS_W-1:0];
		g.box.y = my[drac_pkg::POS_W-1:0];
		g.box.w = 14'(ex - mx);
		g.box.h = 14'(ey - my);
	end

endmodule

/* rtl/core/damage_rect_accumulator_core.sv */
`timescale 1ns / 1ps
// Damage rectangle list with clip, merge and readout.
// Input channel: in_valid / in_stall with mode and rect_x/y/w/h; a beat is
// taken when in_valid is high and in_stall low. in_stall is low only while
// the sequencer is idle, also while a result still waits in the output
// register.
// Output channel: res_valid / out_stall with status, out_x/y/w/h,
// entry_count, valid_res and last; one beat per add or full request, one
// per held rectangle (at least one) per readout, last on the final beat.
// Sequence: drop, overflow, full and readout-empty requests pass from decode
// straight to the emit state; a readout reads each held rectangle from the
// memory and emits it in turn. An add runs the merge scan on the rectangle
// memory: each outer index is read and loaded, then compared with every
// later entry; on each merge the entries behind the merged one move down one
// place and the scan restarts. One request is handled at a time.
// Configuration: cfg_we/cfg_index/cfg_data write width (0) or height (1);
// write only while idle.
// Reset empties the list and loads a 1024 x 768 screen; the memory needs no
// clearing. A stalled receiver holds the output beat and the sequencer
// waits before issuing the next beat.
module damage_rect_accumulator_core #(
	parameter int MAX_RECTS = drac_pkg::MAX_RECTS_DEF,
	localparam int IDX_W = $clog2(MAX_RECTS),
	localparam int CNT_W = $clog2(MAX_RECTS + 1)
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic                                    cfg_index,
	input  logic        [drac_pkg::DIM_W-1:0]       cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic        [1:0]                       mode,
	input  logic signed [drac_pkg::IN_W-1:0]        rect_x,
	input  logic signed [drac_pkg::IN_W-1:0]        rect_y,
	input  logic signed [drac_pkg::IN_W-1:0]        rect_w,
	input  logic signed [drac_pkg::IN_W-1:0]        rect_h,
	output logic                                    res_valid,
	input  logic                                    out_stall,
	output logic        [2:0]                       status,
	output logic        [drac_pkg::POS_W-1:0]       out_x,
	output logic        [drac_pkg::POS_W-1:0]       out_y,
	output logic        [drac_pkg::DIM_W-1:0]       out_w,
	output logic        [drac_pkg::DIM_W-1:0]       out_h,
	output logic        [CNT_W-1:0]                 entry_count,
	output logic                                    valid_res,
	output logic                                    last
);

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECTS);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	drac_pkg::state_t state_q, state_d;

	logic [drac_pkg::DIM_W-1:0] width_q, height_q, fw, fh;
	logic [1:0]                 mode_q;
	logic signed [drac_pkg::IN_W-1:0] x_q, y_q, w_q, h_q;
	logic [CNT_W-1:0]           cnt_q, n_q;
	logic [IDX_W-1:0]           i_q, j_q, k_q;
	drac_pkg::rect_t            ri_q, rdata, mem_wd, full_box;
	drac_pkg::res_t             res_q;
	drac_pkg::clip_t            clip;
	drac_pkg::geom_t            geom;
	logic                       mem_we;
	logic [IDX_W-1:0]           mem_wa, mem_ra;
	logic                       out_free, out_load, ld_last;
	logic [CNT_W-1:0]           i_nx, j_nx, k_nx;

	drac_mem #(.DEPTH(MAX_RECTS)) u_mem (
		.clk(clk), .we(mem_we), .wa(mem_wa), .wd(mem_wd), .ra(mem_ra), .rd(rdata)
	);

	drac_clip u_clip (
		.rect_x(x_q), .rect_y(y_q), .rect_w(w_q), .rect_h(h_q),
		.fw(fw), .fh(fh), .clip(clip)
	);

	drac_geom u_geom (.a(ri_q), .b(rdata), .g(geom));

	always_comb begin
		fw         = (width_q > 14'(drac_pkg::SCREEN_LIMIT)) ?
			14'(drac_pkg::SCREEN_LIMIT) : width_q;
		fh         = (height_q > 14'(drac_pkg::SCREEN_LIMIT)) ?
			14'(drac_pkg::SCREEN_LIMIT) : height_q;
		full_box   = '{x: '0, y: '0, w: fw, h: fh};
		i_nx       = CNT_W'(i_q) + CNT_ONE;
		j_nx       = CNT_W'(j_q) + CNT_ONE;
		k_nx       = CNT_W'(k_q) + CNT_ONE;
		out_free   = !res_valid || !out_stall;
		ld_last    = k_nx == n_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			drac_pkg::S_IDLE: begin
				if (in_valid) state_d = drac_pkg::S_DECODE;
			end
			drac_pkg::S_DECODE: begin
				unique case (mode_q)
					drac_pkg::MODE_ADD: begin
						if (clip.empty || cnt_q >= CNT_MAX) state_d = drac_pkg::S_EMIT;
						else state_d = drac_pkg::S_RD_I;
					end
					drac_pkg::MODE_FULL: state_d = drac_pkg::S_EMIT;
					drac_pkg::MODE_READ: begin
						if (cnt_q == '0) state_d = drac_pkg::S_EMIT;
						else state_d = drac_pkg::S_RO_RD;
					end
					default: state_d = drac_pkg::S_IDLE;
				endcase
			end
			drac_pkg::S_RD_I: begin
				if (i_nx >= cnt_q) state_d = drac_pkg::S_EMIT;
				else state_d = drac_pkg::S_LD_I;
			end
			drac_pkg::S_LD_I: state_d = drac_pkg::S_CMP;
			drac_pkg::S_CMP: begin
				if (geom.near) state_d = drac_pkg::S_SHIFT_RD;
				else if (j_nx >= cnt_q) state_d = drac_pkg::S_RD_I;
			end
			drac_pkg::S_SHIFT_RD: begin
				if (k_nx >= cnt_q) state_d = drac_pkg::S_RD_I;
				else state_d = drac_pkg::S_SHIFT_WR;
			end
			drac_pkg::S_SHIFT_WR: state_d = drac_pkg::S_SHIFT_RD;
			drac_pkg::S_EMIT: begin
				if (out_free) state_d = drac_pkg::S_IDLE;
			end
			drac_pkg::S_RO_RD: state_d = drac_pkg::S_RO_OUT;
			drac_pkg::S_RO_OUT: begin
				if (out_free) state_d = ld_last ? drac_pkg::S_IDLE : drac_pkg::S_RO_RD;
			end
			default: state_d = drac_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_stall = state_q != drac_pkg::S_IDLE;
		mem_we   = 1'b0;
		mem_wa   = '0;
		mem_wd   = full_box;
		mem_ra   = '0;
		out_load = 1'b0;
		unique case (state_q)
			drac_pkg::S_DECODE: begin
				if (mode_q == drac_pkg::MODE_ADD && !clip.empty) begin
					mem_we = 1'b1;
					if (cnt_q < CNT_MAX) begin
						mem_wa = cnt_q[IDX_W-1:0];
						mem_wd = clip.box;
					end
				end else if (mode_q == drac_pkg::MODE_FULL) begin
					mem_we = 1'b1;
				end
			end
			drac_pkg::S_RD_I: mem_ra = i_q;
			drac_pkg::S_LD_I: mem_ra = j_q;
			drac_pkg::S_CMP: begin
				mem_ra = j_nx[IDX_W-1:0];
				if (geom.near) begin
					mem_we = 1'b1;
					mem_wa = i_q;
					mem_wd = geom.box;
				end
			end
			drac_pkg::S_SHIFT_RD: mem_ra = k_nx[IDX_W-1:0];
			drac_pkg::S_SHIFT_WR: begin
				mem_we = 1'b1;
				mem_wa = k_q;
				mem_wd = rdata;
			end
			drac_pkg::S_EMIT:   out_load = out_free;
			drac_pkg::S_RO_RD:  mem_ra = k_q;
			drac_pkg::S_RO_OUT: begin
				mem_ra   = k_q;
				out_load = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= drac_pkg::S_IDLE;
			width_q  <= drac_pkg::WIDTH_RST;
			height_q <= drac_pkg::HEIGHT_RST;
			cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					drac_pkg::CFG_WIDTH:  width_q  <= cfg_data;
					drac_pkg::CFG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == drac_pkg::S_DECODE) begin
				if (mode_q == drac_pkg::MODE_ADD && !clip.empty) begin
					cnt_q <= (cnt_q >= CNT_MAX) ? CNT_ONE : cnt_q + CNT_ONE;
				end else if (mode_q == drac_pkg::MODE_FULL) begin
					cnt_q <= CNT_ONE;
				end else if (mode_q == drac_pkg::MODE_READ) begin
					cnt_q <= '0;
				end
			end else if (state_q == drac_pkg::S_SHIFT_RD && k_nx >= cnt_q) begin
				cnt_q <= cnt_q - CNT_ONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			drac_pkg::S_IDLE: begin
				mode_q <= mode;
				x_q    <= rect_x;
				y_q    <= rect_y;
				w_q    <= rect_w;
				h_q    <= rect_h;
			end
			drac_pkg::S_DECODE: begin
				i_q <= '0;
				k_q <= '0;
				n_q <= cnt_q;
				unique case (mode_q)
					drac_pkg::MODE_ADD: begin
						if (clip.empty) res_q <= '{drac_pkg::ST_DROP, '0, 1'b0};
						else if (cnt_q >= CNT_MAX) res_q <= '{drac_pkg::ST_OVF, full_box, 1'b1};
						else res_q <= '{drac_pkg::ST_ADDED, clip.box, 1'b1};
					end
					drac_pkg::MODE_FULL: res_q <= '{drac_pkg::ST_FULL, full_box, 1'b1};
					default: res_q <= '{drac_pkg::ST_RO, '0, 1'b0};
				endcase
			end
			drac_pkg::S_RD_I: j_q <= i_nx[IDX_W-1:0];
			drac_pkg::S_LD_I: ri_q <= rdata;
			drac_pkg::S_CMP: begin
				if (geom.near) k_q <= j_q;
				else if (j_nx >= cnt_q) i_q <= i_nx[IDX_W-1:0];
				else j_q <= j_nx[IDX_W-1:0];
			end
			drac_pkg::S_SHIFT_RD: begin
				if (k_nx >= cnt_q) i_q <= '0;
			end
			drac_pkg::S_SHIFT_WR: k_q <= k_nx[IDX_W-1:0];
			drac_pkg::S_RO_OUT: begin
				if (out_free && !ld_last) k_q <= k_nx[IDX_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (out_load) begin
			res_valid <= 1'b1;
		end else if (!out_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == drac_pkg::S_RO_OUT) begin
				status      <= drac_pkg::ST_RO;
				out_x       <= rdata.x;
				out_y       <= rdata.y;
				out_w       <= rdata.w;
				out_h       <= rdata.h;
				entry_count <= '0;
				valid_res   <= 1'b1;
				last        <= ld_last;
			end else begin
				status      <= res_q.status;
				out_x       <= res_q.box.x;
				out_y       <= res_q.box.y;
				out_w       <= res_q.box.w;
				out_h       <= res_q.box.h;
				entry_count <= cnt_q;
				valid_res   <= res_q.valid;
				last        <= 1'b1;
			end
		end
	end

`include "damage_rect_accumulator_core_assert.svh"

	`DRAC_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CNT_MAX, "rectangle count above capacity")
	`DRAC_ASSERT_IMPL(a_last_single, res_valid && status != drac_pkg::ST_RO, last,
		"single result not marked last")
	`DRAC_ASSERT_IMPL(a_empty_fields, res_valid && !valid_res, out_w == '0 && out_h == '0,
		"invalid result carries a rectangle")
	`DRAC_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall,
		"second beat taken before decode")

endmodule

/* tb/sv/damage_list_checker.sv */
`timescale 1ns / 1ps
module damage_list_checker #(
	parameter int NRECT = drac_pkg::MAX_RECTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [drac_pkg::DIM_W-1:0]   cfg_data,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [1:0]                   mode,
	input  logic signed [15:0]           rect_x,
	input  logic signed [15:0]           rect_y,
	input  logic signed [15:0]           rect_w,
	input  logic signed [15:0]           rect_h,
	input  logic                         res_valid,
	input  logic                         out_stall,
	input  logic [2:0]                   status,
	input  logic [drac_pkg::POS_W-1:0]   out_x,
	input  logic [drac_pkg::POS_W-1:0]   out_y,
	input  logic [drac_pkg::DIM_W-1:0]   out_w,
	input  logic [drac_pkg::DIM_W-1:0]   out_h,
	input  logic [4:0]                   entry_count,
	input  logic                         valid_res,
	input  logic                         last,
	output int                           errors,
	output int                           pending,
	output int                           beats_seen,
	output int                           overflows
);

	typedef struct {
		logic [2:0]  st;
		logic [12:0] x;
		logic [12:0] y;
		logic [13:0] w;
		logic [13:0] h;
		logic [4:0]  cnt;
		logic        vld;
		logic        lst;
	} beat_t;

	beat_t expected_beats[$];
	logic [13:0] scr_w, scr_h;
	int lx[NRECT], ly[NRECT], lw[NRECT], lh[NRECT];
	int held;

	assign pending = expected_beats.size();

	function automatic int clamp_dim(logic [13:0] r);
		return (r > 14'd8192) ? 8192 : int'(r);
	endfunction

	function automatic bit touching(int i, int j);
		return lx[i] <= lx[j] + lw[j] + 1 && lx[j] <= lx[i] + lw[i] + 1 &&
			ly[i] <= ly[j] + lh[j] + 1 && ly[j] <= ly[i] + lh[i] + 1;
	endfunction

	task automatic push_beat(logic [2:0] st, int x, int y, int w, int h, bit vld, bit lst);
		beat_t b;
		b.st = st;
		b.x = vld ? x[12:0] : '0;
		b.y = vld ? y[12:0] : '0;
		b.w = vld ? w[13:0] : '0;
		b.h = vld ? h[13:0] : '0;
		b.cnt = held[4:0];
		b.vld = vld;
		b.lst = lst;
		expected_beats.push_back(b);
	endtask

	task automatic merge_list();
		bit merged;
		int x2, y2;
		do begin
			merged = 0;
			for (int i = 0; i < held && !merged; i++) begin
				for (int j = i + 1; j < held && !merged; j++) begin
					if (touching(i, j)) begin
						x2 = (lx[i] + lw[i] > lx[j] + lw[j]) ? lx[i] + lw[i] : lx[j] + lw[j];
						y2 = (ly[i] + lh[i] > ly[j] + lh[j]) ? ly[i] + lh[i] : ly[j] + lh[j];
						lx[i] = (lx[i] < lx[j]) ? lx[i] : lx[j];
						ly[i] = (ly[i] < ly[j]) ? ly[i] : ly[j];
						lw[i] = x2 - lx[i];
						lh[i] = y2 - ly[i];
						for (int k = j; k + 1 < held; k++) begin
							lx[k] = lx[k+1];
							ly[k] = ly[k+1];
							lw[k] = lw[k+1];
							lh[k] = lh[k+1];
						end
						held--;
						merged = 1;
					end
				end
			end
		end while (merged);
	endtask

	task automatic apply_request(logic [1:0] m, int x, int y, int w, int h);
		int fw, fh, n;
		fw = clamp_dim(scr_w);
		fh = clamp_dim(scr_h);
		case (m)
			drac_pkg::MODE_ADD: begin
				if (w > 0 && h > 0) begin
					if (x < 0) begin
						w += x;
						x = 0;
					end
					if (y < 0) begin
						h += y;
						y = 0;
					end
					if (x + w > fw) w = fw - x;
					if (y + h > fh) h = fh - y;
				end
				if (w <= 0 || h <= 0) begin
					push_beat(drac_pkg::ST_DROP, 0, 0, 0, 0, 0, 1);
				end else if (held >= NRECT) begin
					lx[0] = 0; ly[0] = 0; lw[0] = fw; lh[0] = fh;
					held = 1;
					overflows++;
					push_beat(drac_pkg::ST_OVF, 0, 0, fw, fh, 1, 1);
				end else begin
					lx[held] = x; ly[held] = y; lw[held] = w; lh[held] = h;
					held++;
					merge_list();
					push_beat(drac_pkg::ST_ADDED, x, y, w, h, 1, 1);
				end
			end
			drac_pkg::MODE_FULL: begin
				lx[0] = 0; ly[0] = 0; lw[0] = fw; lh[0] = fh;
				held = 1;
				push_beat(drac_pkg::ST_FULL, 0, 0, fw, fh, 1, 1);
			end
			drac_pkg::MODE_READ: begin
				n = held;
				held = 0;
				if (n == 0) push_beat(drac_pkg::ST_RO, 0, 0, 0, 0, 0, 1);
				for (int i = 0; i < n; i++)
					push_beat(drac_pkg::ST_RO, lx[i], ly[i], lw[i], lh[i], 1, i + 1 == n);
			end
			default: ;
		endcase
	endtask

	task automatic compare_beat();
		beat_t e;
		if (expected_beats.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%0t: unexpected beat status=%0d", $time, status);
			return;
		end
		e = expected_beats.pop_front();
		if (status !== e.st || out_x !== e.x || out_y !== e.y || out_w !== e.w ||
				out_h !== e.h || entry_count !== e.cnt || valid_res !== e.vld ||
				last !== e.lst) begin
			errors++;
			if (errors <= 10) begin
				$display("%0t: exp st=%0d x=%0d y=%0d w=%0d h=%0d cnt=%0d v=%0d l=%0d",
					$time, e.st, e.x, e.y, e.w, e.h, e.cnt, e.vld, e.lst);
				$display("%0t: got st=%0d x=%0d y=%0d w=%0d h=%0d cnt=%0d v=%0d l=%0d",
					$time, status, out_x, out_y, out_w, out_h, entry_count,
					valid_res, last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w <= drac_pkg::WIDTH_RST;
			scr_h <= drac_pkg::HEIGHT_RST;
			held = 0;
			errors = 0;
			beats_seen = 0;
			overflows = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == drac_pkg::CFG_WIDTH) scr_w <= cfg_data;
				else scr_h <= cfg_data;
			end
			if (in_valid && !in_stall)
				apply_request(mode, int'(rect_x), int'(rect_y), int'(rect_w), int'(rect_h));
			if (res_valid && !out_stall) begin
				beats_seen++;
				compare_beat();
			end
		end
	end
endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;

	localparam logic [1:0] MODE_IGNORED = 2'd3;
	localparam int WATCHDOG_LIMIT = 10000;
	localparam int DRAIN_CYCLES = 600;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic cfg_index = 0;
	logic [drac_pkg::DIM_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] mode = '0;
	logic signed [15:0] rect_x = '0, rect_y = '0, rect_w = '0, rect_h = '0;
	logic res_valid;
	logic out_stall = 0;
	logic [2:0] status;
	logic [drac_pkg::POS_W-1:0] out_x, out_y;
	logic [drac_pkg::DIM_W-1:0] out_w, out_h;
	logic [4:0] entry_count;
	logic valid_res, last;
	int errors, pending, beats_seen, overflows;
	int requests_sent = 0;
	int idle_cycles = 0;
	bit busy_period = 1;
	int cur_w = 1024, cur_h = 768;

	always begin
		clk = 1;
		#5;
		clk = 0;
		#5;
	end

	damage_rect_accumulator_core dut (.*);

	damage_list_checker chk (.*);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (res_valid && !out_stall) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[damage_rect_accumulator_core] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	int rx_hold = 0;
	always @(posedge clk) begin
		if (!busy_period) begin
			out_stall <= 0;
		end else if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
		end else if (out_stall) begin
			out_stall <= 0;
			rx_hold <= $urandom_range(0, 40);
		end else if ($urandom_range(0, 3) == 0) begin
			out_stall <= 1;
			rx_hold <= $urandom_range(0, 18);
		end
	end

	task automatic send_request(logic [1:0] m, int x, int y, int w, int h);
		int gap;
		gap = (busy_period && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		mode <= m;
		rect_x <= x[15:0];
		rect_y <= y[15:0];
		rect_w <= w[15:0];
		rect_h <= h[15:0];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		requests_sent++;
	endtask

	task automatic settle();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_screen(int w, int h);
		settle();
		cfg_we <= 1;
		cfg_index <= drac_pkg::CFG_WIDTH;
		cfg_data <= w[13:0];
		@(posedge clk);
		cfg_index <= drac_pkg::CFG_HEIGHT;
		cfg_data <= h[13:0];
		@(posedge clk);
		cfg_we <= 0;
		cur_w = (w > 8192) ? 8192 : w;
		cur_h = (h > 8192) ? 8192 : h;
	endtask

	task automatic random_request();
		int r, sw, sh;
		sw = (cur_w < 1) ? 1 : cur_w;
		sh = (cur_h < 1) ? 1 : cur_h;
		r = $urandom_range(0, 99);
		if (r < 4) send_request(drac_pkg::MODE_READ, 0, 0, 0, 0);
		else if (r < 7)
			send_request(drac_pkg::MODE_FULL, $urandom, $urandom, $urandom, $urandom);
		else if (r < 9) send_request(MODE_IGNORED, $urandom, $urandom, $urandom, $urandom);
		else if (r < 17)
			send_request(drac_pkg::MODE_ADD, $urandom, $urandom, $urandom, $urandom);
		else
			send_request(drac_pkg::MODE_ADD, int'($urandom_range(0, sw + 20)) - 10,
				int'($urandom_range(0, sh + 20)) - 10,
				$urandom_range(1, 24), $urandom_range(1, 24));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_request(drac_pkg::MODE_READ, 0, 0, 0, 0);
		send_request(drac_pkg::MODE_ADD, -32768, -32768, 32767, 32767);
		send_request(drac_pkg::MODE_ADD, 32767, 32767, 32767, 32767);
		send_request(drac_pkg::MODE_ADD, 10, 10, 0, 5);
		send_request(drac_pkg::MODE_ADD, 10, 10, 5, -1);
		send_request(drac_pkg::MODE_ADD, -32768, 5, -32768, 5);
		send_request(drac_pkg::MODE_READ, 0, 0, 0, 0);
		send_request(drac_pkg::MODE_ADD, 0, 0, 10, 10);
		send_request(drac_pkg::MODE_ADD, 11, 0, 5, 5);
		send_request(drac_pkg::MODE_ADD, 40, 40, 3, 3);
		send_request(drac_pkg::MODE_ADD, 20, 50, 4, 4);
		send_request(drac_pkg::MODE_ADD, 1020, 760, 100, 100);
		send_request(MODE_IGNORED, -1, -1, -1, -1);
		send_request(drac_pkg::MODE_READ, 0, 0, 0, 0);
		send_request(drac_pkg::MODE_FULL, 0, 0, 0, 0);
		send_request(drac_pkg::MODE_ADD, 5, 5, 5, 5);
		send_request(drac_pkg::MODE_READ, 0, 0, 0, 0);
		for (int i = 0; i < 17; i++)
			send_request(drac_pkg::MODE_ADD, (i % 4) * 200, (i / 4) * 150, 20, 20);
		send_request(drac_pkg::MODE_READ, 0, 0, 0, 0);

		// wait once mid-run until every expected result beat has been checked
		settle();
		for (int i = 0; i < 20; i++) random_request();

		set_screen(16383, 9000);
		for (int i = 0; i < 20; i++) random_request();
		set_screen(0, 5);
		for (int i = 0; i < 8; i++) random_request();
		send_request(drac_pkg::MODE_FULL, 0, 0, 0, 0);
		send_request(drac_pkg::MODE_READ, 0, 0, 0, 0);
		set_screen(1, 1);
		for (int i = 0; i < 8; i++) random_request();
		send_request(drac_pkg::MODE_READ, 0, 0, 0, 0);
		set_screen(8192, 8192);
		for (int i = 0; i < 20; i++) random_request();
		set_screen(640, 480);
		busy_period = 0;
		for (int i = 0; i < 15; i++) random_request();
		send_request(drac_pkg::MODE_READ, 0, 0, 0, 0);

		settle();
		$display("Sent %0d requests over six screen sizes; %0d result beats checked.",
			requests_sent, beats_seen);
		$display("List overflows seen: %0d; mismatches: %0d.", overflows, errors);
		if (errors == 0 && pending == 0) begin
			$display("[damage_rect_accumulator_core] OK");
		end else begin
			$display("[damage_rect_accumulator_core] ERROR");
		end
		$finish;
	end
endmodule
